@@ rtl/tve_pkg.sv @@
// Shared types and constants of the text value escaper.
`default_nettype none
package tve_pkg;

   // Byte codes that the escaping rules test for or produce.
   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_NL   = 8'h0A;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_BS   = 8'h5C;
   localparam logic [7:0] CH_TIL  = 8'h7E;

   // Most output bytes that one input byte can cause.
   localparam int RUN_MAX   = 4;
   localparam int RUN_IDX_W = $clog2(RUN_MAX);
   localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);

   // Depth of the queue between the classifier and the serializer.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Escaper phase, one-hot.
   typedef enum logic [3:0] {
      PH_START   = 4'b0001,
      PH_NORMAL  = 4'b0010,
      PH_SPACE   = 4'b0100,
      PH_NEWLINE = 4'b1000
   } phase_type;

   // One run of output bytes caused by a single input byte.
   typedef struct packed {
      logic [RUN_IDX_W-1:0]        last_idx;
      logic [RUN_MAX-1:0][7:0]     bytes;
   } run_type;

   // Write request from the classifier into the queue.
   typedef struct packed {
      logic    valid;
      run_type run;
   } push_type;

   // Queue occupancy flags.
   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage : tve_pkg
`default_nettype wire

@@ rtl/tve_front.sv @@
// Classifier: accepts input bytes, tracks the escape state and builds output runs.
`default_nettype none
module tve_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_tdata,   // [7:0] in_byte
   input  tve_pkg::qstat_type      qstat,
   output tve_pkg::push_type       push
);
   import tve_pkg::*;

   phase_type                      phase_ff, phase_in;
   logic [1:0]                     held_ff, held_in;
   logic [RUN_CNT_W-1:0]           n;
   logic [RUN_MAX-1:0][7:0]        run_bytes;
   logic [7:0]                     in_byte;
   logic                           accept;
   logic                           is_ws;
   logic                           two;

   assign in_byte    = req_tdata;
   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;
   assign is_ws      = (in_byte >= 8'd1) && (in_byte <= CH_SP);
   assign two        = (held_ff == 2'd2);

   // Escape rules: next state and the bytes this input produces.
   always_comb begin
      n         = '0;
      run_bytes = '0;
      phase_in  = phase_ff;
      held_in   = held_ff;
      if (in_byte == CH_CR) begin
         // Carriage return is dropped and leaves the state alone.
      end else if (in_byte == CH_NUL) begin
         phase_in = PH_START;
         held_in  = '0;
      end else begin
         case (phase_ff)
            PH_START: begin
               if (in_byte == CH_BS || is_ws) begin
                  run_bytes[n[RUN_IDX_W-1:0]] = CH_BS;
                  n = n + 1'b1;
               end
               run_bytes[n[RUN_IDX_W-1:0]] = in_byte;
               n = n + 1'b1;
               phase_in = PH_NORMAL;
            end
            PH_NORMAL, PH_SPACE: begin
               if (in_byte == CH_BS) begin
                  run_bytes[0] = CH_BS;
                  run_bytes[1] = CH_BS;
                  n = RUN_CNT_W'(2);
                  phase_in = PH_NORMAL;
               end else if (in_byte == CH_NL) begin
                  phase_in = PH_NEWLINE;
                  held_in  = 2'd1;
               end else if (is_ws) begin
                  if (in_byte == CH_SP && phase_ff != PH_SPACE) begin
                     run_bytes[0] = in_byte;
                     n = RUN_CNT_W'(1);
                     phase_in = PH_SPACE;
                  end else begin
                     run_bytes[0] = CH_BS;
                     run_bytes[1] = in_byte;
                     n = RUN_CNT_W'(2);
                     phase_in = PH_NORMAL;
                  end
               end else begin
                  run_bytes[0] = in_byte;
                  n = RUN_CNT_W'(1);
                  phase_in = PH_NORMAL;
               end
            end
            PH_NEWLINE: begin
               if (in_byte == CH_NL) begin
                  if (two) begin
                     // A third newline flushes as newline, newline, backslash, newline.
                     run_bytes[0] = CH_NL;
                     run_bytes[1] = CH_NL;
                     run_bytes[2] = CH_BS;
                     run_bytes[3] = CH_NL;
                     n = RUN_CNT_W'(4);
                     phase_in = PH_NORMAL;
                     held_in  = '0;
                  end else begin
                     held_in = 2'd2;
                  end
               end else begin
                  // Held newlines come out ahead of this byte.
                  run_bytes[0] = two ? CH_NL : CH_BS;
                  run_bytes[1] = CH_NL;
                  n = RUN_CNT_W'(2);
                  if (in_byte == CH_TIL || in_byte == CH_HASH || in_byte == CH_BS) begin
                     if (two) begin
                        run_bytes[n[RUN_IDX_W-1:0]] = CH_BS;
                        n = n + 1'b1;
                     end
                     phase_in = PH_NORMAL;
                  end else if (is_ws) begin
                     if (two) begin
                        run_bytes[n[RUN_IDX_W-1:0]] = CH_BS;
                        n = n + 1'b1;
                     end
                     phase_in = PH_SPACE;
                  end else begin
                     phase_in = PH_NORMAL;
                  end
                  run_bytes[n[RUN_IDX_W-1:0]] = in_byte;
                  n = n + 1'b1;
                  held_in = '0;
               end
            end
            default: begin
               phase_in = PH_START;
               held_in  = '0;
            end
         endcase
      end
   end

   // Only inputs that produce at least one word enter the queue.
   assign push.valid         = accept && (n != '0);
   assign push.run.bytes     = run_bytes;
   assign push.run.last_idx  = RUN_IDX_W'(n - 1'b1);

   // State registers advance on each accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         held_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule : tve_front
`default_nettype wire

@@ rtl/tve_queue.sv @@
// Small queue of output runs between the classifier and the serializer.
`default_nettype none
module tve_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  tve_pkg::push_type       push,
   input  wire logic               pop,
   output tve_pkg::run_type        head,
   output tve_pkg::qstat_type      qstat
);
   import tve_pkg::*;

   run_type                 mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       cnt_ff, cnt_in;
   logic                    do_push, do_pop;

   assign qstat.empty = (cnt_ff == '0);
   assign qstat.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push     = push.valid && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Run storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.run;
      end
   end

endmodule : tve_queue
`default_nettype wire

@@ rtl/tve_back.sv @@
// Serializer: sends the bytes of the run at the queue head one word at a time.
`default_nettype none
module tve_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  tve_pkg::run_type        head,
   input  tve_pkg::qstat_type      qstat,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_tdata,   // [7:0] out_byte
   output logic                    rsp_tlast    // run_last
);
   import tve_pkg::*;

   logic [RUN_IDX_W-1:0]    idx_ff, idx_in;
   logic                    xfer;

   assign rsp_tvalid = !qstat.empty;
   assign rsp_tdata  = head.bytes[idx_ff];
   assign rsp_tlast  = (idx_ff == head.last_idx);
   assign xfer       = rsp_tvalid && rsp_tready;
   assign pop        = xfer && rsp_tlast;

   // Byte index within the current run.
   always_comb begin
      idx_in = idx_ff;
      if (pop) begin
         idx_in = '0;
      end else if (xfer) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule : tve_back
`default_nettype wire

@@ rtl/text_value_escaper_top.sv @@
// Top level of the text value escaper.
//
// Usage: text bytes enter on the req_ channel, one word per byte; byte 0 ends a
// value and returns the escaper to its start phase. Escaped bytes leave on the
// rsp_ channel, one word per byte, and rsp_tlast marks the final byte caused by
// one input byte. An input byte causes zero to four output words.
// An accepted byte's run is written into the run queue, and the first word of
// that run appears on rsp_ once the runs ahead of it have been sent.
// Throughput: one input word per cycle while the queue has room; the output side
// sends one word per cycle while rsp_tready is high. A four-entry run queue lets
// the input side keep running while the output side works through longer runs.
// Stalls: when rsp_tready is low, the current word holds and the queue fills;
// req_tready drops only when the queue holds four pending runs.
// Reset: synchronous and active high; it empties the queue and sets the start
// phase with no held newlines.
`default_nettype none
module text_value_escaper_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] in_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,    // [7:0] out_byte
   output logic             rsp_tlast     // run_last
);
   import tve_pkg::*;

   push_type   push;
   run_type    head;
   qstat_type  qstat;
   logic       pop;

   tve_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .qstat      (qstat),
      .push       (push)
   );

   tve_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .qstat (qstat)
   );

   tve_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule : text_value_escaper_top
`default_nettype wire

@@ rtl/tve_checker.sv @@
// Port-level checks of the text value escaper, bound to the top level.
`default_nettype none
module tve_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,
   input  wire logic        rsp_tlast
);
   import tve_pkg::*;

   // Reset leaves nothing to send and room to accept.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("output pending or input blocked after reset");

   // A stalled output word holds its byte and its last flag.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled output word changed");

   // Output words only follow accepted input words.
   a_no_invent : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("output word appeared without an input word");

   // The end byte and carriage return are never written out.
   a_no_dropped_bytes : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata != CH_NUL && rsp_tdata != CH_CR)
      else $error("end byte or carriage return on output");

endmodule : tve_checker

bind text_value_escaper_top tve_checker u_tve_checker (.*);
`default_nettype wire
